// ===== hdl/rch_pkg.sv =====
// shared types, constants and codes of the ray closest-hit block
package rch_pkg;

  // fixed point format and scene size
  localparam int FRAC_BITS = 16;
  localparam int SLOTS     = 4;
  localparam int SLOT_W    = 2;

  // shared multiplier: MUL_W x MUL_W magnitude product, MUL_CH bits of b per pass
  localparam int MUL_W  = 36;
  localparam int MUL_CH = 18;
  localparam int PROD_W = 2 * MUL_W;

  // shift-subtract unit: one quotient or root bit per step
  localparam int SS_STEPS = 32;
  localparam int SS_REM_W = 37;
  localparam int SS_SRC_W = 64;

  // command codes of the input word
  localparam logic [1:0] CMD_LOAD_SPHERE = 2'd0;
  localparam logic [1:0] CMD_LOAD_PLANE  = 2'd1;
  localparam logic [1:0] CMD_CAST        = 2'd2;

  // configuration register indexes
  localparam logic CFG_MAX_DIST  = 1'b0;
  localparam logic CFG_PLANE_EPS = 1'b1;

  // request to the shared multiplier
  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // request to the shift-subtract unit (divide or square root)
  typedef struct packed {
    logic                start;
    logic                sqrt;
    logic [SS_REM_W-1:0] rem_init;
    logic [SS_SRC_W-1:0] src;
    logic [MUL_W-1:0]    den;
  } ss_req_t;

endpackage

// ===== hdl/rch_in_if.sv =====
// input word channel: load and cast commands
interface rch_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [1:0]         slot;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [17:0] b_x;
  logic signed [17:0] b_y;
  logic signed [17:0] b_z;
  logic [30:0]        sphere_radius;

  modport source (
    output valid, command, slot, a_x, a_y, a_z, b_x, b_y, b_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, command, slot, a_x, a_y, a_z, b_x, b_y, b_z, sphere_radius,
    output ready
  );
endinterface

// ===== hdl/rch_out_if.sv =====
// result word channel: closest hit of one cast
interface rch_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] distance;
  logic [2:0]  object_id;

  modport source (
    output valid, hit, distance, object_id,
    input  ready
  );
  modport sink (
    input  valid, hit, distance, object_id,
    output ready
  );
endinterface

// ===== hdl/rch_mul.sv =====
// shared magnitude multiplier, two partial products of b per operation
module rch_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rch_pkg::mul_req_t         req_i,
  output logic                      done_o,
  output logic [rch_pkg::PROD_W-1:0] prod_o
);

  localparam int PP_W = rch_pkg::MUL_W + rch_pkg::MUL_CH;

  typedef enum logic [3:0] {
    MS_IDLE = 4'b0001,
    MS_LO   = 4'b0010,
    MS_HI   = 4'b0100,
    MS_ACC  = 4'b1000
  } mul_state_e;

  mul_state_e                  state_q;
  logic                        done_q;
  logic [rch_pkg::MUL_W-1:0]   a_q;
  logic [rch_pkg::MUL_W-1:0]   b_q;
  logic [PP_W-1:0]             pp_q;
  logic [PP_W-1:0]             pp_d;
  logic [rch_pkg::MUL_CH-1:0]  chunk;
  logic [rch_pkg::PROD_W-1:0]  prod_q;

  // pick the half of b for this pass
  always_comb begin
    chunk = (state_q == MS_LO) ? b_q[rch_pkg::MUL_CH-1:0]
                               : b_q[rch_pkg::MUL_W-1:rch_pkg::MUL_CH];
    pp_d  = PP_W'(a_q) * PP_W'(chunk);
  end

  // sequencing of the passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == MS_ACC);
      case (state_q)
        MS_IDLE: if (req_i.start) state_q <= MS_LO;
        MS_LO:   state_q <= MS_HI;
        MS_HI:   state_q <= MS_ACC;
        MS_ACC:  state_q <= MS_IDLE;
        default: state_q <= MS_IDLE;
      endcase
    end
  end

  // operands, partial product and sum
  always_ff @(posedge clk_i) begin
    case (state_q)
      MS_IDLE: begin
        if (req_i.start) begin
          a_q <= req_i.a;
          b_q <= req_i.b;
        end
      end
      MS_LO: pp_q <= pp_d;
      MS_HI: begin
        pp_q   <= pp_d;
        prod_q <= {{rch_pkg::MUL_CH{1'b0}}, pp_q};
      end
      MS_ACC: prod_q <= prod_q + {pp_q, {rch_pkg::MUL_CH{1'b0}}};
      default: pp_q <= pp_q;
    endcase
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== hdl/rch_shsub.sv =====
// shift-subtract unit: restoring divide or integer square root, one bit per cycle
module rch_shsub (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rch_pkg::ss_req_t  req_i,
  output logic              done_o,
  output logic [31:0]       q_o
);

  localparam int CAND_W = rch_pkg::SS_REM_W + 1;

  logic                          busy_q;
  logic                          done_q;
  logic [4:0]                    cnt_q;
  logic                          sqrt_q;
  logic [rch_pkg::SS_REM_W-1:0]  rem_q;
  logic [31:0]                   q_q;
  logic [rch_pkg::SS_SRC_W-1:0]  src_q;
  logic [rch_pkg::MUL_W-1:0]     den_q;
  logic [CAND_W-1:0]             cand;
  logic [CAND_W-1:0]             sub;
  logic [CAND_W-1:0]             diff;
  logic                          ge;

  // one step: bring down bits, trial subtract
  always_comb begin
    if (sqrt_q) begin
      cand = {rem_q[rch_pkg::SS_REM_W-2:0], src_q[rch_pkg::SS_SRC_W-1 -: 2]};
      sub  = CAND_W'({q_q, 2'b01});
    end else begin
      cand = {rem_q, src_q[rch_pkg::SS_SRC_W-1]};
      sub  = CAND_W'(den_q);
    end
    ge   = (cand >= sub);
    diff = cand - sub;
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'(rch_pkg::SS_STEPS - 1));
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(rch_pkg::SS_STEPS - 1)) busy_q <= 1'b0;
      end
    end
  end

  // remainder, result and source bits
  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        sqrt_q <= req_i.sqrt;
        rem_q  <= req_i.rem_init;
        src_q  <= req_i.src;
        den_q  <= req_i.den;
        q_q    <= '0;
      end
    end else begin
      rem_q <= ge ? diff[rch_pkg::SS_REM_W-1:0] : cand[rch_pkg::SS_REM_W-1:0];
      q_q   <= {q_q[30:0], ge};
      src_q <= sqrt_q ? {src_q[rch_pkg::SS_SRC_W-3:0], 2'b00}
                      : {src_q[rch_pkg::SS_SRC_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

// ===== hdl/ray_closest_hit_sphere_plane_top.sv =====
// top level: scene store, cast sequencer and result register
//
// Closest-hit tester for one plane and four spheres in Q16.16 fixed point.
// item_i carries load sphere, load plane and cast words; only a cast gives a
// word on res_o (hit, distance, object_id). The cfg port writes max_distance
// (index 0) and plane_epsilon (index 1) and must be used only while idle.
// A load is written into the scene store from the idle state. A cast walks
// the plane and each valid sphere slot through one shared 36x36 multiplier
// (two 36x18 passes per product) and one shift-subtract unit (divide or
// square root); the multiplier and the bit-serial divide/root set how long
// a cast runs. item_i.ready is high only while the sequencer is idle. The
// result sits in an output register, so the next word is taken while a
// result still waits; a second cast holds in its last step until res_o is
// free. Reset empties the scene, sets max_distance to its largest value and
// plane_epsilon to zero, and drops res_o.valid.
module ray_closest_hit_sphere_plane_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  rch_in_if.sink      item_i,
  rch_out_if.source   res_o
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_PL_DN  = 13'b0000000000010,
    ST_PL_NUM = 13'b0000000000100,
    ST_PL_CHK = 13'b0000000001000,
    ST_PL_DIV = 13'b0000000010000,
    ST_SP_SEL = 13'b0000000100000,
    ST_SP_DOT = 13'b0000001000000,
    ST_SP_TCA = 13'b0000010000000,
    ST_SP_TSQ = 13'b0000100000000,
    ST_SP_RSQ = 13'b0001000000000,
    ST_SP_SQ  = 13'b0010000000000,
    ST_SP_NXT = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } state_e;

  localparam int F = rch_pkg::FRAC_BITS;

  state_e state_q;

  // scene store
  logic signed [31:0]        cx_q [rch_pkg::SLOTS];
  logic signed [31:0]        cy_q [rch_pkg::SLOTS];
  logic signed [31:0]        cz_q [rch_pkg::SLOTS];
  logic [30:0]               rad_q [rch_pkg::SLOTS];
  logic [rch_pkg::SLOTS-1:0] svalid_q;
  logic signed [31:0]        pp_q [3];
  logic signed [17:0]        pn_q [3];
  logic                      pvalid_q;
  logic [30:0]               maxd_q;
  logic [15:0]               eps_q;

  // cast working registers
  logic signed [31:0]          org_q [3];
  logic signed [17:0]          dir_q [3];
  logic signed [53:0]          acc_q;
  logic [49:0]                 lsq_q;
  logic signed [36:0]          dn_q;
  logic [35:0]                 tca_q;
  logic [49:0]                 d2_q;
  logic [30:0]                 best_q;
  logic                        hit_q;
  logic [2:0]                  id_q;
  logic [rch_pkg::SLOT_W-1:0]  k_q;
  logic [1:0]                  i_q;
  logic                        part_q;
  logic                        mwait_q;

  // result register
  logic        ovalid_q;
  logic        ohit_q;
  logic [30:0] odist_q;
  logic [2:0]  oid_q;

  // unit connections
  rch_pkg::mul_req_t           mul_req;
  logic                        mul_done;
  logic [rch_pkg::PROD_W-1:0]  mul_prod;
  rch_pkg::ss_req_t            ss_req;
  logic                        ss_done;
  logic [31:0]                 ss_q;

  // combinational datapath signals
  logic signed [31:0] osel, ppsel, csel;
  logic signed [17:0] dsel, pnsel;
  logic signed [32:0] pdiff, ldiff;
  logic [32:0]        pdiff_mag, ldiff_mag;
  logic [17:0]        dsel_mag, pnsel_mag;
  logic               neg;
  logic               mul_fire;
  logic signed [53:0] prod_s, acc_add;
  logic [53:0]        nmag;
  logic [36:0]        dmag;
  logic               pl_skip;
  logic [55:0]        tsq;
  logic [49:0]        d2_d;
  logic [45:0]        r2;
  logic [49:0]        r2_ext;
  logic [49:0]        rd_diff;
  logic               sp_miss;
  logic [35:0]        tch;
  logic [36:0]        sp_t;
  logic               pl_take, sp_take;

  // component selection for the current axis
  always_comb begin
    case (i_q)
      2'd0: begin
        osel = org_q[0]; dsel = dir_q[0]; ppsel = pp_q[0]; pnsel = pn_q[0];
        csel = cx_q[k_q];
      end
      2'd1: begin
        osel = org_q[1]; dsel = dir_q[1]; ppsel = pp_q[1]; pnsel = pn_q[1];
        csel = cy_q[k_q];
      end
      default: begin
        osel = org_q[2]; dsel = dir_q[2]; ppsel = pp_q[2]; pnsel = pn_q[2];
        csel = cz_q[k_q];
      end
    endcase
    pdiff     = 33'(ppsel) - 33'(osel);
    ldiff     = 33'(csel) - 33'(osel);
    pdiff_mag = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
    ldiff_mag = ldiff[32] ? 33'(-ldiff) : 33'(ldiff);
    dsel_mag  = dsel[17] ? 18'(-dsel) : 18'(dsel);
    pnsel_mag = pnsel[17] ? 18'(-pnsel) : 18'(pnsel);
  end

  // multiplier operands per step
  always_comb begin
    mul_req = '0;
    neg     = 1'b0;
    case (state_q)
      ST_PL_DN: begin
        mul_req.a = 36'(pnsel_mag);
        mul_req.b = 36'(dsel_mag);
        neg       = pnsel[17] ^ dsel[17];
      end
      ST_PL_NUM: begin
        mul_req.a = 36'(pdiff_mag);
        mul_req.b = 36'(pnsel_mag);
        neg       = pdiff[32] ^ pnsel[17];
      end
      ST_SP_DOT: begin
        mul_req.a = 36'(ldiff_mag);
        if (!part_q) begin
          mul_req.b = 36'(dsel_mag);
          neg       = ldiff[32] ^ dsel[17];
        end else begin
          mul_req.b = 36'(ldiff_mag);
        end
      end
      ST_SP_TSQ: begin
        mul_req.a = tca_q;
        mul_req.b = tca_q;
      end
      ST_SP_RSQ: begin
        mul_req.a = 36'(rad_q[k_q]);
        mul_req.b = 36'(rad_q[k_q]);
      end
      default: mul_req = '0;
    endcase
    mul_req.start = !mwait_q && (state_q == ST_PL_DN || state_q == ST_PL_NUM ||
                    state_q == ST_SP_DOT || state_q == ST_SP_TSQ ||
                    state_q == ST_SP_RSQ);
  end

  // signed accumulate of dot product terms
  always_comb begin
    mul_fire = mwait_q && mul_done;
    prod_s   = signed'({1'b0, mul_prod[52:0]});
    acc_add  = neg ? (acc_q - prod_s) : (acc_q + prod_s);
  end

  // plane checks before the divide
  always_comb begin
    nmag    = acc_q[53] ? (54'd0 - acc_q) : acc_q;
    dmag    = dn_q[36] ? (37'd0 - dn_q) : dn_q;
    pl_skip = (dmag <= (37'(eps_q) << F))
           || ((acc_q != 54'sd0) && (acc_q[53] != dn_q[36]))
           || (nmag >= (54'(dmag) << F));
    pl_take = (ss_q != 32'd0) && (ss_q < 32'(best_q));
  end

  // sphere distances
  always_comb begin
    tsq     = mul_prod[71:F];
    d2_d    = (56'(lsq_q) > tsq) ? 50'(56'(lsq_q) - tsq) : 50'd0;
    r2      = mul_prod[61:F];
    r2_ext  = 50'(r2);
    sp_miss = (d2_q > r2_ext);
    rd_diff = r2_ext - d2_q;
    tch     = 36'(ss_q);
    sp_t    = (tch > tca_q) ? (37'(tca_q) + 37'(tch)) : 37'(tca_q - tch);
    sp_take = (sp_t != 37'd0) && (sp_t < 37'(best_q));
  end

  // divide or square root request
  always_comb begin
    ss_req = '0;
    if (state_q == ST_PL_CHK) begin
      ss_req.start    = !pl_skip;
      ss_req.sqrt     = 1'b0;
      ss_req.rem_init = 37'(nmag >> F);
      ss_req.src      = {nmag[F-1:0], {(rch_pkg::SS_SRC_W - F){1'b0}}};
      ss_req.den      = dmag[35:0];
    end else if (state_q == ST_SP_RSQ) begin
      ss_req.start = mul_fire && !sp_miss;
      ss_req.sqrt  = 1'b1;
      ss_req.src   = 64'({rd_diff[45:0], {F{1'b0}}});
    end
  end

  rch_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  rch_shsub u_shsub (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ss_req),
    .done_o (ss_done),
    .q_o    (ss_q)
  );

  // sequencer, scene writes and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      svalid_q <= '0;
      pvalid_q <= 1'b0;
      maxd_q   <= 31'h7fffffff;
      eps_q    <= '0;
      mwait_q  <= 1'b0;
      part_q   <= 1'b0;
      i_q      <= '0;
      k_q      <= '0;
      ovalid_q <= 1'b0;
      ohit_q   <= 1'b0;
      odist_q  <= '0;
      oid_q    <= '0;
      hit_q    <= 1'b0;
      id_q     <= '0;
      acc_q    <= '0;
      lsq_q    <= '0;
      dn_q     <= '0;
      tca_q    <= '0;
      d2_q     <= '0;
      best_q   <= '0;
      for (int s = 0; s < rch_pkg::SLOTS; s++) begin
        cx_q[s]  <= '0;
        cy_q[s]  <= '0;
        cz_q[s]  <= '0;
        rad_q[s] <= '0;
      end
      for (int j = 0; j < 3; j++) begin
        pp_q[j]  <= '0;
        pn_q[j]  <= '0;
        org_q[j] <= '0;
        dir_q[j] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        if (cfg_idx_i == rch_pkg::CFG_MAX_DIST) maxd_q <= cfg_data_i;
        else eps_q <= cfg_data_i[15:0];
      end

      // result word taken
      if (ovalid_q && res_o.ready && state_q != ST_OUT) ovalid_q <= 1'b0;

      if (mul_req.start) mwait_q <= 1'b1;
      else if (mul_fire) mwait_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (item_i.valid) begin
            case (item_i.command)
              rch_pkg::CMD_LOAD_SPHERE: begin
                cx_q[item_i.slot]     <= item_i.a_x;
                cy_q[item_i.slot]     <= item_i.a_y;
                cz_q[item_i.slot]     <= item_i.a_z;
                rad_q[item_i.slot]    <= item_i.sphere_radius;
                svalid_q[item_i.slot] <= 1'b1;
              end
              rch_pkg::CMD_LOAD_PLANE: begin
                pp_q[0]  <= item_i.a_x;
                pp_q[1]  <= item_i.a_y;
                pp_q[2]  <= item_i.a_z;
                pn_q[0]  <= item_i.b_x;
                pn_q[1]  <= item_i.b_y;
                pn_q[2]  <= item_i.b_z;
                pvalid_q <= 1'b1;
              end
              rch_pkg::CMD_CAST: begin
                org_q[0] <= item_i.a_x;
                org_q[1] <= item_i.a_y;
                org_q[2] <= item_i.a_z;
                dir_q[0] <= item_i.b_x;
                dir_q[1] <= item_i.b_y;
                dir_q[2] <= item_i.b_z;
                best_q   <= maxd_q;
                hit_q    <= 1'b0;
                id_q     <= '0;
                acc_q    <= '0;
                i_q      <= '0;
                k_q      <= '0;
                state_q  <= pvalid_q ? ST_PL_DN : ST_SP_SEL;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        // normal dot direction
        ST_PL_DN: begin
          if (mul_fire) begin
            if (i_q == 2'd2) begin
              dn_q    <= acc_add[36:0];
              acc_q   <= '0;
              i_q     <= '0;
              state_q <= ST_PL_NUM;
            end else begin
              acc_q <= acc_add;
              i_q   <= i_q + 2'd1;
            end
          end
        end

        // (point - origin) dot normal
        ST_PL_NUM: begin
          if (mul_fire) begin
            acc_q <= acc_add;
            if (i_q == 2'd2) begin
              i_q     <= '0;
              state_q <= ST_PL_CHK;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end

        ST_PL_CHK: state_q <= pl_skip ? ST_SP_SEL : ST_PL_DIV;

        ST_PL_DIV: begin
          if (ss_done) begin
            if (pl_take) begin
              best_q <= ss_q[30:0];
              hit_q  <= 1'b1;
              id_q   <= '0;
            end
            state_q <= ST_SP_SEL;
          end
        end

        ST_SP_SEL: begin
          if (svalid_q[k_q]) begin
            acc_q   <= '0;
            lsq_q   <= '0;
            i_q     <= '0;
            part_q  <= 1'b0;
            state_q <= ST_SP_DOT;
          end else begin
            state_q <= ST_SP_NXT;
          end
        end

        // L dot d and squared length of L
        ST_SP_DOT: begin
          if (mul_fire) begin
            if (!part_q) begin
              acc_q  <= acc_add;
              part_q <= 1'b1;
            end else begin
              lsq_q  <= lsq_q + 50'(mul_prod[63:F]);
              part_q <= 1'b0;
              if (i_q == 2'd2) begin
                i_q     <= '0;
                state_q <= ST_SP_TCA;
              end else begin
                i_q <= i_q + 2'd1;
              end
            end
          end
        end

        ST_SP_TCA: begin
          if (acc_q[53]) begin
            state_q <= ST_SP_NXT;
          end else begin
            tca_q   <= acc_q[51:F];
            state_q <= ST_SP_TSQ;
          end
        end

        ST_SP_TSQ: begin
          if (mul_fire) begin
            d2_q    <= d2_d;
            state_q <= ST_SP_RSQ;
          end
        end

        ST_SP_RSQ: begin
          if (mul_fire) state_q <= sp_miss ? ST_SP_NXT : ST_SP_SQ;
        end

        ST_SP_SQ: begin
          if (ss_done) begin
            if (sp_take) begin
              best_q <= sp_t[30:0];
              hit_q  <= 1'b1;
              id_q   <= 3'(k_q) + 3'd1;
            end
            state_q <= ST_SP_NXT;
          end
        end

        ST_SP_NXT: begin
          if (k_q == rch_pkg::SLOT_W'(rch_pkg::SLOTS - 1)) begin
            state_q <= ST_OUT;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SP_SEL;
          end
        end

        // hand the result to the output register
        ST_OUT: begin
          if (!ovalid_q || res_o.ready) begin
            ovalid_q <= 1'b1;
            ohit_q   <= hit_q;
            odist_q  <= hit_q ? best_q : 31'd0;
            oid_q    <= hit_q ? id_q : 3'd0;
            state_q  <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign item_i.ready    = (state_q == ST_IDLE);
  assign res_o.valid     = ovalid_q;
  assign res_o.hit       = ohit_q;
  assign res_o.distance  = odist_q;
  assign res_o.object_id = oid_q;

  // a hit always carries a nonzero distance, a miss carries zeros
  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.hit ? (res_o.distance != 31'd0)
                               : (res_o.distance == 31'd0 && res_o.object_id == 3'd0)))
    else $error("result word fields inconsistent with hit flag");

  // object id never beyond the last sphere slot
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.object_id <= 3'(rch_pkg::SLOTS)))
    else $error("object id out of range");

  // a new result only comes from the output step of the sequencer
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == ST_OUT))
    else $error("result valid raised outside the output step");

endmodule
